>>> rtl/core/valu_pkg.sv
// Shared constants, types and helpers for the four-lane vector ALU.
`default_nettype none
package valu_pkg;

    localparam int LANE_MAX      = 4;
    localparam int DATA_W        = 32;
    localparam int SQRT_BITS     = 36;
    localparam int RAD_W         = 2 * SQRT_BITS;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_LANES     = 4;

    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MUL    = 4'd2;
    localparam logic [3:0] OP_DIV    = 4'd3;
    localparam logic [3:0] OP_SCALE  = 4'd4;
    localparam logic [3:0] OP_MAG    = 4'd5;
    localparam logic [3:0] OP_NORM   = 4'd6;
    localparam logic [3:0] OP_DIST   = 4'd7;
    localparam logic [3:0] OP_EQUAL  = 4'd8;
    localparam logic [3:0] OP_ISZERO = 4'd9;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    typedef logic signed [DATA_W-1:0] t_word;

    // Item context carried alongside the root and divide pipelines
    typedef struct packed {
        logic [3:0]                   op;
        t_word [LANE_MAX-1:0]         a;
        t_word [LANE_MAX-1:0]         b;
        t_word [LANE_MAX-1:0]         res;
        logic                         ovf;
        logic                         flag;
        logic [SQRT_BITS-1:0]         root;
    } t_side;

    // Per-lane divide flags
    typedef struct packed {
        logic neg;
        logic dz;
        logic apos;
        logic aneg;
    } t_dflag;

    // {overflow, saturated 32-bit value}
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return {1'b1, WORD_MAX};
        end else if (v < 64'shFFFF_FFFF_8000_0000) begin
            return {1'b1, WORD_MIN};
        end
        return {1'b0, v[31:0]};
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/valu_front.sv
// Front end: lane add/sub, products, squares and sum of squares (three stages).
`default_nettype none
module valu_front import valu_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int LANES     = DEF_LANES
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire                       i_vld,
    input  wire  [3:0]                i_op,
    input  t_word [LANE_MAX-1:0]      i_a,
    input  t_word [LANE_MAX-1:0]      i_b,
    input  t_word                     i_f,
    output logic                      o_vld,
    output logic [RAD_W-1:0]          o_rad,
    output t_side                     o_side
);

    localparam int NL = (LANES < LANE_MAX) ? LANES : LANE_MAX;

    // stage 1
    logic signed [31:0] a_m   [LANE_MAX];
    logic signed [31:0] b_m   [LANE_MAX];
    logic signed [31:0] m_op  [LANE_MAX];
    logic signed [32:0] sum_w [LANE_MAX];
    logic signed [32:0] dif_w [LANE_MAX];
    logic signed [32:0] src   [LANE_MAX];
    logic        [32:0] src_n [LANE_MAX];
    logic        [32:0] sat_s [LANE_MAX];
    logic        [32:0] sat_d [LANE_MAX];
    logic               eq_all, zr_all;

    logic [31:0]        n1_res  [LANE_MAX];
    logic signed [63:0] n1_prod [LANE_MAX];
    logic [31:0]        n1_mag  [LANE_MAX];
    logic               n1_ovf, n1_flag;

    logic               r1_vld;
    logic [3:0]         r1_op;
    logic [31:0]        r1_a    [LANE_MAX];
    logic [31:0]        r1_b    [LANE_MAX];
    logic [31:0]        r1_res  [LANE_MAX];
    logic signed [63:0] r1_prod [LANE_MAX];
    logic [31:0]        r1_mag  [LANE_MAX];
    logic               r1_ovf, r1_flag;

    always_comb begin
        n1_ovf = 1'b0;
        eq_all = 1'b1;
        zr_all = 1'b1;
        for (int i = 0; i < LANE_MAX; i++) begin
            a_m[i]   = (i < NL) ? i_a[i] : '0;
            b_m[i]   = (i < NL) ? i_b[i] : '0;
            sum_w[i] = {a_m[i][31], a_m[i]} + {b_m[i][31], b_m[i]};
            dif_w[i] = {a_m[i][31], a_m[i]} - {b_m[i][31], b_m[i]};
            sat_s[i] = sat32({{31{sum_w[i][32]}}, sum_w[i]});
            sat_d[i] = sat32({{31{dif_w[i][32]}}, dif_w[i]});
            case (i_op)
                OP_ADD: begin
                    n1_res[i] = sat_s[i][31:0];
                    n1_ovf    = n1_ovf | sat_s[i][32];
                end
                OP_SUB: begin
                    n1_res[i] = sat_d[i][31:0];
                    n1_ovf    = n1_ovf | sat_d[i][32];
                end
                default: n1_res[i] = '0;
            endcase
            m_op[i]    = (i_op == OP_SCALE) ? ((i < NL) ? i_f : '0) : b_m[i];
            n1_prod[i] = a_m[i] * m_op[i];
            src[i]     = (i_op == OP_DIST) ? dif_w[i] : {a_m[i][31], a_m[i]};
            src_n[i]   = -src[i];
            n1_mag[i]  = src[i][32] ? src_n[i][31:0] : src[i][31:0];
            if (a_m[i] != b_m[i]) eq_all = 1'b0;
            if (a_m[i] != '0)     zr_all = 1'b0;
        end
        n1_flag = (i_op == OP_EQUAL)  ? eq_all :
                  (i_op == OP_ISZERO) ? zr_all : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op   <= i_op;
            r1_ovf  <= n1_ovf;
            r1_flag <= n1_flag;
            for (int i = 0; i < LANE_MAX; i++) begin
                r1_a[i]    <= a_m[i];
                r1_b[i]    <= b_m[i];
                r1_res[i]  <= n1_res[i];
                r1_prod[i] <= n1_prod[i];
                r1_mag[i]  <= n1_mag[i];
            end
        end
    end

    // stage 2: product scaling and squares
    logic signed [63:0] shf   [LANE_MAX];
    logic        [32:0] sat_m [LANE_MAX];
    logic        [63:0] n2_sq [LANE_MAX];
    t_side              n2_side;

    logic               r2_vld;
    logic        [63:0] r2_sq [LANE_MAX];
    t_side              r2_side;

    always_comb begin
        n2_side      = '0;
        n2_side.op   = r1_op;
        n2_side.flag = r1_flag;
        n2_side.ovf  = r1_ovf;
        for (int i = 0; i < LANE_MAX; i++) begin
            shf[i]   = r1_prod[i] >>> FRAC_BITS;
            sat_m[i] = sat32(shf[i]);
            n2_side.a[i] = r1_a[i];
            n2_side.b[i] = r1_b[i];
            if (r1_op == OP_MUL || r1_op == OP_SCALE) begin
                n2_side.res[i] = sat_m[i][31:0];
                n2_side.ovf    = n2_side.ovf | sat_m[i][32];
            end else begin
                n2_side.res[i] = r1_res[i];
            end
            n2_sq[i] = r1_mag[i] * r1_mag[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= n2_side;
            for (int i = 0; i < LANE_MAX; i++) begin
                r2_sq[i] <= n2_sq[i];
            end
        end
    end

    // stage 3: sum of squares
    logic [RAD_W-1:0] n3_rad;
    logic             r3_vld;
    logic [RAD_W-1:0] r3_rad;
    t_side            r3_side;

    always_comb begin
        n3_rad = '0;
        for (int i = 0; i < LANE_MAX; i++) begin
            n3_rad = n3_rad + RAD_W'(r2_sq[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_rad  <= n3_rad;
            r3_side <= r2_side;
        end
    end

    assign o_vld  = r3_vld;
    assign o_rad  = r3_rad;
    assign o_side = r3_side;

endmodule
`default_nettype wire

>>> rtl/core/valu_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module valu_sqrt import valu_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  wire               i_vld,
    input  wire  [RAD_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_vld,
    output t_side             o_side
);

    localparam int SB = SQRT_BITS;
    localparam int RW = SQRT_BITS + 2;

    logic          r_vld  [SB];
    logic [RAD_W-1:0] r_rad [SB];
    logic [RW-1:0] r_rem  [SB];
    logic [SB-1:0] r_root [SB];
    t_side         r_side [SB];

    for (genvar k = 0; k < SB; k++) begin : g_stg
        logic             v_in;
        logic [RAD_W-1:0] rad_in;
        logic [RW-1:0]    rem_in;
        logic [SB-1:0]    root_in;
        t_side            side_in;
        logic [RW-1:0]    rem_sh, trial, n_rem;
        logic [SB-1:0]    n_root;
        logic             ge;

        if (k == 0) begin : g_first
            assign v_in    = i_vld;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[RW-3:0], rad_in[RAD_W-1 -: 2]};
            trial  = {root_in, 2'b01};
            ge     = (rem_sh >= trial);
            n_rem  = ge ? (rem_sh - trial) : rem_sh;
            n_root = {root_in[SB-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {rad_in[RAD_W-3:0], 2'b00};
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= side_in;
            end
        end
    end

    always_comb begin
        o_side      = r_side[SB-1];
        o_side.root = r_root[SB-1];
    end
    assign o_vld = r_vld[SB-1];

endmodule
`default_nettype wire

>>> rtl/core/valu_div.sv
// Pipelined four-lane restoring divider for div and normalize.
`default_nettype none
module valu_div import valu_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_vld,
    input  t_side                   i_side,
    output logic                    o_vld,
    output t_side                   o_side,
    output logic [DATA_W+FRAC_BITS-1:0] o_q [LANE_MAX],
    output t_dflag                  o_flg [LANE_MAX]
);

    localparam int NW = DATA_W + FRAC_BITS;
    localparam int DW = SQRT_BITS;

    // entry stage: magnitudes and sign handling
    logic [31:0]   amag [LANE_MAX];
    logic [31:0]   bmag [LANE_MAX];
    logic [NW-1:0] n_num [LANE_MAX];
    logic [DW-1:0] n_den [LANE_MAX];
    t_dflag        n_flg [LANE_MAX];

    logic          r_e_vld;
    t_side         r_e_side;
    logic [NW-1:0] r_e_num [LANE_MAX];
    logic [DW-1:0] r_e_den [LANE_MAX];
    t_dflag        r_e_flg [LANE_MAX];

    always_comb begin
        for (int i = 0; i < LANE_MAX; i++) begin
            amag[i]  = i_side.a[i][31] ? (~i_side.a[i] + 32'd1) : i_side.a[i];
            bmag[i]  = i_side.b[i][31] ? (~i_side.b[i] + 32'd1) : i_side.b[i];
            n_num[i] = {amag[i], {FRAC_BITS{1'b0}}};
            n_den[i] = (i_side.op == OP_NORM) ? i_side.root : DW'(bmag[i]);
            n_flg[i].dz   = (n_den[i] == '0);
            n_flg[i].neg  = i_side.a[i][31] ^ ((i_side.op == OP_NORM) ? 1'b0 : i_side.b[i][31]);
            n_flg[i].apos = !i_side.a[i][31] && (i_side.a[i] != '0);
            n_flg[i].aneg = i_side.a[i][31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_e_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_side <= i_side;
            for (int i = 0; i < LANE_MAX; i++) begin
                r_e_num[i] <= n_num[i];
                r_e_den[i] <= n_den[i];
                r_e_flg[i] <= n_flg[i];
            end
        end
    end

    // one quotient bit per stage
    logic          r_vld  [NW];
    t_side         r_side [NW];
    logic [NW-1:0] r_num  [NW][LANE_MAX];
    logic [NW-1:0] r_q    [NW][LANE_MAX];
    logic [DW-1:0] r_rem  [NW][LANE_MAX];
    logic [DW-1:0] r_den  [NW][LANE_MAX];
    t_dflag        r_flg  [NW][LANE_MAX];

    for (genvar k = 0; k < NW; k++) begin : g_stg
        logic          v_in;
        t_side         side_in;
        logic [NW-1:0] num_in [LANE_MAX];
        logic [NW-1:0] q_in   [LANE_MAX];
        logic [DW-1:0] rem_in [LANE_MAX];
        logic [DW-1:0] den_in [LANE_MAX];
        t_dflag        flg_in [LANE_MAX];
        logic [DW:0]   rem_sh [LANE_MAX];
        logic [DW:0]   rem_df [LANE_MAX];
        logic          ge     [LANE_MAX];
        logic [DW-1:0] n_rem  [LANE_MAX];
        logic [NW-1:0] n_q    [LANE_MAX];

        if (k == 0) begin : g_first
            assign v_in    = r_e_vld;
            assign side_in = r_e_side;
            always_comb begin
                for (int i = 0; i < LANE_MAX; i++) begin
                    num_in[i] = r_e_num[i];
                    q_in[i]   = '0;
                    rem_in[i] = '0;
                    den_in[i] = r_e_den[i];
                    flg_in[i] = r_e_flg[i];
                end
            end
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign side_in = r_side[k-1];
            always_comb begin
                for (int i = 0; i < LANE_MAX; i++) begin
                    num_in[i] = r_num[k-1][i];
                    q_in[i]   = r_q[k-1][i];
                    rem_in[i] = r_rem[k-1][i];
                    den_in[i] = r_den[k-1][i];
                    flg_in[i] = r_flg[k-1][i];
                end
            end
        end

        always_comb begin
            for (int i = 0; i < LANE_MAX; i++) begin
                rem_sh[i] = {rem_in[i], num_in[i][NW-1]};
                rem_df[i] = rem_sh[i] - {1'b0, den_in[i]};
                ge[i]     = (rem_sh[i] >= {1'b0, den_in[i]});
                n_rem[i]  = ge[i] ? rem_df[i][DW-1:0] : rem_sh[i][DW-1:0];
                n_q[i]    = {q_in[i][NW-2:0], ge[i]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= side_in;
                for (int i = 0; i < LANE_MAX; i++) begin
                    r_num[k][i] <= {num_in[i][NW-2:0], 1'b0};
                    r_q[k][i]   <= n_q[i];
                    r_rem[k][i] <= n_rem[i];
                    r_den[k][i] <= den_in[i];
                    r_flg[k][i] <= flg_in[i];
                end
            end
        end
    end

    assign o_vld  = r_vld[NW-1];
    assign o_side = r_side[NW-1];
    always_comb begin
        for (int i = 0; i < LANE_MAX; i++) begin
            o_q[i]   = r_q[NW-1][i];
            o_flg[i] = r_flg[NW-1][i];
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/four_lane_vector_alu.sv
// Top level of the four-lane fixed-point vector ALU.
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: a, b, factor; tuser: action
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: r lanes, scalar, flag, status
//
// One transaction accepted per cycle unless the output stalls; values are
// Q16.16 by default. Depth is set by the 36-stage root pipeline and the
// one-bit-per-stage divider. All stages move together on one enable that drops
// only while a result sits unclaimed at the output. Reset clears the valid bits only.
`default_nettype none
module four_lane_vector_alu import valu_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int LANES     = DEF_LANES
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, factor (32 bits each)
    input  wire  [287:0] i_s_axis_tdata,
    // action
    input  wire  [3:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // r_x, r_y, r_z, r_w (32 each), scalar_out (31), compare_flag, status (2), zero pad
    output logic [167:0] o_m_axis_tdata
);

    localparam int NL = (LANES < LANE_MAX) ? LANES : LANE_MAX;
    localparam int NW = DATA_W + FRAC_BITS;
    localparam logic [NW-1:0] Q_PLIM = NW'(33'h0_7FFF_FFFF);
    localparam logic [NW-1:0] Q_NLIM = NW'(33'h0_8000_0000);
    localparam logic [SQRT_BITS-1:0] ROOT_LIM = SQRT_BITS'(32'h7FFF_FFFF);

    logic         en;
    logic         r_m_vld;
    logic [167:0] r_m_data;

    assign en              = !r_m_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    t_word [LANE_MAX-1:0] in_a, in_b;
    t_word                in_f;

    always_comb begin
        for (int i = 0; i < LANE_MAX; i++) begin
            in_a[i] = i_s_axis_tdata[32*i +: 32];
            in_b[i] = i_s_axis_tdata[32*(i+LANE_MAX) +: 32];
        end
        in_f = i_s_axis_tdata[287:256];
    end

    logic             f_vld;
    logic [RAD_W-1:0] f_rad;
    t_side            f_side;
    logic             s_vld;
    t_side            s_side;
    logic             d_vld;
    t_side            d_side;
    logic [NW-1:0]    d_q   [LANE_MAX];
    t_dflag           d_flg [LANE_MAX];

    valu_front #(
        .FRAC_BITS (FRAC_BITS),
        .LANES     (LANES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_axis_tvalid),
        .i_op    (i_s_axis_tuser),
        .i_a     (in_a),
        .i_b     (in_b),
        .i_f     (in_f),
        .o_vld   (f_vld),
        .o_rad   (f_rad),
        .o_side  (f_side)
    );

    valu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_rad   (f_rad),
        .i_side  (f_side),
        .o_vld   (s_vld),
        .o_side  (s_side)
    );

    valu_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_vld),
        .i_side  (s_side),
        .o_vld   (d_vld),
        .o_side  (d_side),
        .o_q     (d_q),
        .o_flg   (d_flg)
    );

    // output stage: lane saturation, result select, status
    logic [NW-1:0] qn   [LANE_MAX];
    logic [31:0]   dv   [LANE_MAX];
    logic          dov  [LANE_MAX];
    logic [31:0]   lane [LANE_MAX];
    logic [30:0]   scalar;
    logic          dz_any, ovf_any, is_div;
    logic [1:0]    status;
    logic [167:0]  n_m_data;

    always_comb begin
        is_div  = (d_side.op == OP_DIV) || (d_side.op == OP_NORM);
        dz_any  = 1'b0;
        ovf_any = d_side.ovf;
        for (int i = 0; i < LANE_MAX; i++) begin
            qn[i]  = ~d_q[i] + NW'(1);
            dov[i] = 1'b0;
            if (d_flg[i].dz) begin
                dv[i] = d_flg[i].apos ? WORD_MAX : (d_flg[i].aneg ? WORD_MIN : '0);
            end else if (d_flg[i].neg) begin
                if (d_q[i] > Q_NLIM) begin
                    dv[i]  = WORD_MIN;
                    dov[i] = 1'b1;
                end else begin
                    dv[i] = qn[i][31:0];
                end
            end else if (d_q[i] > Q_PLIM) begin
                dv[i]  = WORD_MAX;
                dov[i] = 1'b1;
            end else begin
                dv[i] = d_q[i][31:0];
            end
            if (is_div) begin
                if (i < NL) begin
                    lane[i] = dv[i];
                    dz_any  = dz_any | d_flg[i].dz;
                    ovf_any = ovf_any | dov[i];
                end else begin
                    lane[i] = '0;
                end
            end else begin
                lane[i] = d_side.res[i];
            end
        end
        if (d_side.op == OP_MAG || d_side.op == OP_DIST) begin
            if (d_side.root > ROOT_LIM) begin
                scalar  = WORD_MAX[30:0];
                ovf_any = 1'b1;
            end else begin
                scalar = d_side.root[30:0];
            end
        end else begin
            scalar = '0;
        end
        status   = dz_any ? ST_DZ : (ovf_any ? ST_SAT : ST_OK);
        n_m_data = {6'b0, status, d_side.flag, scalar, lane[3], lane[2], lane[1], lane[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_m_axis_tvalid = r_m_vld;
    assign o_m_axis_tdata  = r_m_data;

endmodule
`default_nettype wire
